### hdl/srcf_pkg.sv
package srcf_pkg;

	localparam int unsigned REASSEMBLY_BYTES = 2560;
	localparam int unsigned MAX_WINDOW = 16;

	typedef enum logic [1:0] {PH_IDLE = 2'd0, PH_SEGREQ = 2'd1, PH_AWAIT = 2'd2,
		PH_SEGCONF = 2'd3} phase_t;

	localparam logic [1:0] OP_CLIENT = 2'd0;
	localparam logic [1:0] OP_PDU = 2'd1;
	localparam logic [1:0] OP_TIMER = 2'd2;

	localparam logic [2:0] PT_CONFREQ = 3'd0;
	localparam logic [2:0] PT_UNCONF = 3'd1;
	localparam logic [2:0] PT_SIMPLEACK = 3'd2;
	localparam logic [2:0] PT_COMPLEXACK = 3'd3;
	localparam logic [2:0] PT_SEGACK = 3'd4;
	localparam logic [2:0] PT_ABORT = 3'd7;

	localparam logic [1:0] DST_NONE = 2'd0;
	localparam logic [1:0] DST_NET = 2'd1;
	localparam logic [1:0] DST_CLIENT = 2'd2;

	localparam logic [2:0] ACT_FORWARD = 3'd0;
	localparam logic [2:0] ACT_REQSEG = 3'd1;
	localparam logic [2:0] ACT_SEGACK = 3'd2;
	localparam logic [2:0] ACT_ABORT = 3'd3;
	localparam logic [2:0] ACT_RESULT = 3'd4;

	localparam logic [2:0] AK_SEGUNSUP = 3'd0;
	localparam logic [2:0] AK_INVALID = 3'd1;
	localparam logic [2:0] AK_TIMEOUT = 3'd2;
	localparam logic [2:0] AK_OVERFLOW = 3'd3;
	localparam logic [2:0] AK_CLIENT = 3'd4;

	localparam logic [2:0] TM_NONE = 3'd0;
	localparam logic [2:0] TM_APDU = 3'd1;
	localparam logic [2:0] TM_SEG = 3'd2;
	localparam logic [2:0] TM_RESTART = 3'd3;
	localparam logic [2:0] TM_STOP = 3'd4;

	localparam logic [2:0] ERR_OK = 3'd0;
	localparam logic [2:0] ERR_BUSY = 3'd1;
	localparam logic [2:0] ERR_BADADDR = 3'd2;
	localparam logic [2:0] ERR_NULLADDR = 3'd3;
	localparam logic [2:0] ERR_IDLEABORT = 3'd4;

	localparam logic [1:0] REG_RETRY = 2'd0;
	localparam logic [1:0] REG_WINDOW = 2'd1;
	localparam logic [1:0] REG_SEGMODE = 2'd2;
	localparam logic [1:0] REG_MAXAPDU = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic [2:0] pdu_type;
		logic [1:0] addr_class;
		logic [15:0] pdu_length;
		logic [10:0] peer_max_apdu;
		logic segmented;
		logic more_follows;
		logic [7:0] sequence_req;
		logic [6:0] peer_window;
		logic [7:0] reason_in;
		logic [7:0] new_invoke_id;
	} in_word_t;

	typedef struct packed {
		logic [1:0] dest;
		logic [2:0] action;
		logic [7:0] segment_index;
		logic nak;
		logic [7:0] ack_sequence;
		logic [6:0] ack_window;
		logic [2:0] abort_kind;
		logic [7:0] abort_reason;
		logic [7:0] invoke_id;
		logic [2:0] timer_cmd;
		logic [2:0] error_code;
		logic last;
	} out_word_t;

	function automatic logic [6:0] clamp_win(input logic [6:0] w);
		if (w == 7'd0) return 7'd1;
		if (w > 7'(MAX_WINDOW)) return 7'(MAX_WINDOW);
		return w;
	endfunction

	// controller to datapath
	typedef struct packed {
		logic load;        // latch input word
		logic div_start;   // start segment count division
	} dp_cmd_t;

endpackage

### hdl/srcf_if.sv
interface srcf_in_if;
	import srcf_pkg::*;
	logic valid;
	logic ready;
	in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface srcf_out_if;
	import srcf_pkg::*;
	logic valid;
	logic ready;
	out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/srcf_div.sv
module srcf_div
	import srcf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [15:0] dividend,
	input logic [10:0] divisor,
	output logic busy,
	output logic [15:0] quotient,
	output logic rem_nz
);
	logic [4:0] cnt_q;
	logic [15:0] quo_q;
	logic [11:0] rem_q;
	logic [11:0] trial;
	logic [12:0] diff;

	assign trial = {rem_q[10:0], quo_q[15]};
	assign diff = {1'b0, trial} - {2'b00, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
		end else if (start) begin
			cnt_q <= 5'd16;
			quo_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != 5'd0) begin
			cnt_q <= cnt_q - 5'd1;
			if (!diff[12]) begin
				rem_q <= diff[11:0];
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != 5'd0);
	assign quotient = quo_q;
	assign rem_nz = (rem_q != 12'd0);
endmodule

### hdl/srcf_datapath.sv
module srcf_datapath
	import srcf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input dp_cmd_t cmd,
	input in_word_t in_word,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [10:0] cfg_data,
	output in_word_t w_q,
	output logic div_busy,
	output logic [8:0] count,
	output logic [3:0] retry_limit,
	output logic [6:0] proposed_window,
	output logic [1:0] segmentation_mode,
	output logic [10:0] local_max_apdu
);
	logic [3:0] retry_q;
	logic [6:0] pwin_q;
	logic [1:0] mode_q;
	logic [10:0] lmax_q;
	logic [10:0] raw;
	logic [10:0] chunk;
	logic fits;
	logic [15:0] quo;
	logic rnz;
	logic [16:0] cnt_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_q <= 4'd3;
			pwin_q <= 7'd1;
			mode_q <= 2'd3;
			lmax_q <= 11'd1476;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RETRY: retry_q <= cfg_data[3:0];
				REG_WINDOW: pwin_q <= cfg_data[6:0];
				REG_SEGMODE: mode_q <= cfg_data[1:0];
				REG_MAXAPDU: lmax_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) w_q <= in_word;
	end

	assign raw = (w_q.peer_max_apdu == 11'd0 || w_q.peer_max_apdu > lmax_q)
		? lmax_q : w_q.peer_max_apdu;
	assign fits = ({1'b0, w_q.pdu_length} + 17'd4) <= {6'd0, raw};
	assign chunk = (raw > 11'd6) ? raw - 11'd6 : 11'd1;

	// dividend taken from the incoming word, divisor from the latched word
	srcf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(in_word.pdu_length), .divisor(chunk),
		.busy(div_busy), .quotient(quo), .rem_nz(rnz)
	);

	assign cnt_full = {1'b0, quo} + {16'd0, rnz};
	always_comb begin
		if (fits || cnt_full == 17'd0) count = 9'd1;
		else if (cnt_full > 17'd255) count = 9'd256;
		else count = cnt_full[8:0];
	end

	assign retry_limit = retry_q;
	assign proposed_window = pwin_q;
	assign segmentation_mode = mode_q;
	assign local_max_apdu = lmax_q;
endmodule

### hdl/srcf_ctrl.sv
module srcf_ctrl
	import srcf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	srcf_in_if.sink in_ch,
	srcf_out_if.source out_ch,
	input in_word_t w_q,
	input logic div_busy,
	input logic [8:0] count,
	input logic [3:0] retry_limit,
	input logic [6:0] proposed_window,
	input logic [1:0] segmentation_mode,
	input logic [10:0] local_max_apdu,
	output dp_cmd_t cmd
);
	typedef enum logic [2:0] {S_IDLE, S_DIV, S_DECIDE, S_FILL, S_EMIT2} st_t;

	st_t st_q;
	phase_t phase_q;
	logic [7:0] inv_q, tot_q, done_q, wss_q, lrs_q;
	logic [3:0] rr_q, wr_q;
	logic [6:0] win_q;
	logic [11:0] rb_q;
	logic [6:0] fix_q;
	logic [2:0] ftimer_q;
	logic [1:0] e2_dest_q;
	logic [2:0] e2_act_q, e2_kind_q;
	logic ovalid_q;
	out_word_t o_q;

	logic [7:0] diff;
	logic [8:0] done_n;
	logic [12:0] rb_sum;
	logic fill_more;

	assign diff = w_q.sequence_req - wss_q;
	assign done_n = {1'b0, done_q} + {1'b0, diff} + 9'd1;
	assign rb_sum = {1'b0, rb_q} + w_q.pdu_length[12:0];
	assign fill_more = ({1'b0, fix_q} < {1'b0, win_q}) &&
		({1'b0, done_q} + {2'b0, fix_q} < {1'b0, tot_q});

	assign in_ch.ready = (st_q == S_IDLE) && !ovalid_q;
	assign out_ch.valid = ovalid_q;
	assign out_ch.data = o_q;

	always_comb begin
		cmd = '0;
		cmd.load = in_ch.valid && in_ch.ready;
		cmd.div_start = cmd.load;
	end

	function automatic out_word_t mk(input logic [1:0] d, input logic [2:0] a,
			input logic [2:0] k, input logic [2:0] t, input logic [2:0] e,
			input logic [7:0] inv, input logic l);
		out_word_t r;
		r = '0;
		r.dest = d; r.action = a; r.abort_kind = k; r.timer_cmd = t;
		r.error_code = e; r.invoke_id = inv; r.last = l;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin : p_fsm
		st_t st_n;
		logic ovalid_n;
		out_word_t o_n;
		if (!arst_n) begin
			st_q <= S_IDLE; phase_q <= PH_IDLE;
			inv_q <= '0; tot_q <= '0; done_q <= '0; wss_q <= '0; lrs_q <= '0;
			rr_q <= '0; wr_q <= '0; win_q <= 7'd1; rb_q <= '0;
			fix_q <= '0; ftimer_q <= '0; e2_dest_q <= '0; e2_act_q <= '0;
			e2_kind_q <= '0; ovalid_q <= 1'b0; o_q <= '0;
		end else begin
			st_n = st_q;
			ovalid_n = ovalid_q;
			o_n = o_q;
			if (ovalid_q && out_ch.ready) ovalid_n = 1'b0;
			unique case (st_q)
				S_IDLE: if (cmd.load) st_n = S_DIV;
				S_DIV: if (!div_busy) st_n = S_DECIDE;
				S_DECIDE: begin
					st_n = S_IDLE;
					unique case (w_q.op)
						OP_CLIENT: begin
							if (w_q.pdu_type != PT_ABORT && phase_q != PH_IDLE) begin
								o_n = mk(DST_NONE, ACT_FORWARD, 3'd0, TM_NONE, ERR_BUSY, inv_q, 1'b1);
								ovalid_n = 1'b1;
							end else if (w_q.pdu_type == PT_CONFREQ) begin
								ovalid_n = 1'b1;
								if (w_q.addr_class != 2'd1 && w_q.addr_class != 2'd2)
									o_n = mk(DST_NONE, ACT_FORWARD, 3'd0, TM_NONE, ERR_BADADDR, inv_q, 1'b1);
								else if (count > 9'd1 && segmentation_mode[1])
									o_n = mk(DST_CLIENT, ACT_ABORT, AK_SEGUNSUP, TM_NONE, ERR_OK,
										w_q.new_invoke_id, 1'b1);
								else if (count > 9'd255)
									o_n = mk(DST_CLIENT, ACT_ABORT, AK_OVERFLOW, TM_NONE, ERR_OK,
										w_q.new_invoke_id, 1'b1);
								else begin
									o_n = mk(DST_NET, ACT_REQSEG, 3'd0,
										(count == 9'd1) ? TM_APDU : TM_SEG, ERR_OK,
										w_q.new_invoke_id, 1'b1);
									tot_q <= count[7:0]; rr_q <= '0; done_q <= '0; wr_q <= '0;
									wss_q <= '0; win_q <= clamp_win(proposed_window);
									phase_q <= (count == 9'd1) ? PH_AWAIT : PH_SEGREQ;
								end
								if (w_q.addr_class == 2'd1 || w_q.addr_class == 2'd2)
									inv_q <= w_q.new_invoke_id;
							end else if (w_q.pdu_type == PT_UNCONF) begin
								if (w_q.addr_class == 2'd0) begin
									o_n = mk(DST_NONE, ACT_FORWARD, 3'd0, TM_NONE, ERR_NULLADDR, inv_q, 1'b1);
									ovalid_n = 1'b1;
								end else if (w_q.pdu_length <= {5'd0, local_max_apdu}) begin
									o_n = mk(DST_NET, ACT_FORWARD, 3'd0, TM_NONE, ERR_OK, inv_q, 1'b1);
									ovalid_n = 1'b1;
								end
							end else if (w_q.pdu_type == PT_ABORT) begin
								ovalid_n = 1'b1;
								if (phase_q == PH_IDLE)
									o_n = mk(DST_NONE, ACT_FORWARD, 3'd0, TM_NONE, ERR_IDLEABORT, inv_q, 1'b1);
								else begin
									o_n = mk(DST_NET, ACT_ABORT, AK_CLIENT, TM_STOP, ERR_OK, inv_q, 1'b1);
									o_n.abort_reason = w_q.reason_in;
									phase_q <= PH_IDLE;
								end
							end else begin
								o_n = mk(DST_CLIENT, ACT_ABORT, AK_INVALID, TM_NONE, ERR_OK, inv_q, 1'b1);
								ovalid_n = 1'b1;
							end
						end
						OP_PDU: begin
							if (phase_q == PH_SEGREQ || phase_q == PH_AWAIT) begin
								if (w_q.pdu_type == PT_CONFREQ || w_q.pdu_type == PT_UNCONF) begin
									o_n = mk(DST_NET, ACT_ABORT, AK_INVALID, TM_STOP, ERR_OK, inv_q, 1'b0);
									ovalid_n = 1'b1; e2_kind_q <= AK_INVALID;
									e2_dest_q <= DST_CLIENT; e2_act_q <= ACT_ABORT;
									phase_q <= PH_IDLE; st_n = S_EMIT2;
								end else if (w_q.pdu_type == PT_COMPLEXACK) begin
									ovalid_n = 1'b1;
									if (!w_q.segmented) begin
										o_n = mk(DST_CLIENT, ACT_FORWARD, 3'd0, TM_STOP, ERR_OK, inv_q, 1'b1);
										phase_q <= PH_IDLE;
									end else if (w_q.sequence_req != 8'd0) begin
										o_n = mk(DST_NET, ACT_ABORT, AK_INVALID, TM_STOP, ERR_OK, inv_q, 1'b0);
										e2_kind_q <= AK_INVALID; e2_dest_q <= DST_CLIENT;
										e2_act_q <= ACT_ABORT; phase_q <= PH_IDLE; st_n = S_EMIT2;
									end else begin
										rb_q <= (w_q.pdu_length <= 16'(REASSEMBLY_BYTES))
											? w_q.pdu_length[11:0] : 12'd0;
										win_q <= clamp_win(w_q.peer_window);
										o_n = mk(DST_NET, ACT_SEGACK, 3'd0, TM_SEG, ERR_OK, inv_q, 1'b1);
										o_n.ack_window = clamp_win(w_q.peer_window);
										lrs_q <= '0; wss_q <= '0; phase_q <= PH_SEGCONF;
									end
								end else if (w_q.pdu_type == PT_SEGACK) begin
									if (phase_q == PH_SEGREQ) begin
										if ({1'b0, diff} >= {2'b0, win_q}) begin
											o_n = mk(DST_NONE, ACT_FORWARD, 3'd0, TM_RESTART, ERR_OK, inv_q, 1'b1);
											ovalid_n = 1'b1;
										end else if (done_n >= {1'b0, tot_q}) begin
											done_q <= tot_q; phase_q <= PH_AWAIT;
											o_n = mk(DST_NONE, ACT_FORWARD, 3'd0, TM_APDU, ERR_OK, inv_q, 1'b1);
											ovalid_n = 1'b1;
										end else begin
											done_q <= done_n[7:0]; wss_q <= done_n[7:0];
											win_q <= clamp_win(w_q.peer_window);
											fix_q <= '0; ftimer_q <= TM_RESTART; st_n = S_FILL;
										end
									end
								end else begin
									o_n = mk(DST_CLIENT, ACT_FORWARD, 3'd0, TM_STOP, ERR_OK, inv_q, 1'b1);
									ovalid_n = 1'b1; phase_q <= PH_IDLE;
								end
							end else if (phase_q == PH_SEGCONF) begin
								ovalid_n = 1'b1;
								if (w_q.pdu_type <= PT_SIMPLEACK || w_q.pdu_type == PT_SEGACK ||
										(w_q.pdu_type == PT_COMPLEXACK && !w_q.segmented)) begin
									o_n = mk(DST_NET, ACT_ABORT, AK_INVALID, TM_STOP, ERR_OK, inv_q, 1'b0);
									e2_kind_q <= AK_INVALID; e2_dest_q <= DST_CLIENT;
									e2_act_q <= ACT_ABORT; phase_q <= PH_IDLE; st_n = S_EMIT2;
								end else if (w_q.pdu_type != PT_COMPLEXACK) begin
									o_n = mk(DST_CLIENT, ACT_FORWARD, 3'd0, TM_STOP, ERR_OK, inv_q, 1'b1);
									phase_q <= PH_IDLE;
								end else if (w_q.sequence_req != lrs_q + 8'd1) begin
									o_n = mk(DST_NET, ACT_SEGACK, 3'd0, TM_RESTART, ERR_OK, inv_q, 1'b1);
									o_n.nak = 1'b1; o_n.ack_sequence = lrs_q;
									o_n.ack_window = win_q; wss_q <= lrs_q;
								end else if ({1'b0, rb_q} + {1'b0, w_q.pdu_length} >
										17'(REASSEMBLY_BYTES)) begin
									o_n = mk(DST_NET, ACT_ABORT, AK_OVERFLOW, TM_STOP, ERR_OK, inv_q, 1'b0);
									e2_kind_q <= AK_OVERFLOW; e2_dest_q <= DST_CLIENT;
									e2_act_q <= ACT_ABORT; phase_q <= PH_IDLE; st_n = S_EMIT2;
								end else begin
									rb_q <= rb_sum[11:0];
									lrs_q <= lrs_q + 8'd1;
									if (!w_q.more_follows) begin
										o_n = mk(DST_NET, ACT_SEGACK, 3'd0, TM_STOP, ERR_OK, inv_q, 1'b0);
										o_n.ack_sequence = lrs_q + 8'd1; o_n.ack_window = win_q;
										e2_kind_q <= AK_SEGUNSUP; e2_dest_q <= DST_CLIENT;
										e2_act_q <= ACT_RESULT; phase_q <= PH_IDLE; st_n = S_EMIT2;
									end else if (w_q.sequence_req == wss_q + 8'(win_q)) begin
										o_n = mk(DST_NET, ACT_SEGACK, 3'd0, TM_RESTART, ERR_OK, inv_q, 1'b1);
										o_n.ack_sequence = lrs_q + 8'd1; o_n.ack_window = win_q;
										wss_q <= lrs_q + 8'd1;
									end else ovalid_n = 1'b0;
								end
							end
						end
						OP_TIMER: begin
							if (phase_q == PH_SEGREQ && wr_q < retry_limit) begin
								wr_q <= wr_q + 4'd1; fix_q <= '0; ftimer_q <= TM_SEG; st_n = S_FILL;
							end else if (phase_q == PH_AWAIT && rr_q < retry_limit) begin
								rr_q <= rr_q + 4'd1; done_q <= '0; wr_q <= '0; wss_q <= '0;
								win_q <= 7'd1;
								phase_q <= (tot_q <= 8'd1) ? PH_AWAIT : PH_SEGREQ;
								o_n = mk(DST_NET, ACT_REQSEG, 3'd0,
									(tot_q <= 8'd1) ? TM_APDU : TM_SEG, ERR_OK, inv_q, 1'b1);
								ovalid_n = 1'b1;
							end else if (phase_q != PH_IDLE) begin
								o_n = mk(DST_CLIENT, ACT_ABORT, AK_TIMEOUT, TM_NONE, ERR_OK, inv_q, 1'b1);
								ovalid_n = 1'b1; phase_q <= PH_IDLE;
							end
						end
						default: ;
					endcase
				end
				S_FILL: begin
					// one segment per cycle while the output is not held; last flag looks ahead one step
					if (!ovalid_q || out_ch.ready) begin
						if (fill_more) begin
							o_n = mk(DST_NET, ACT_REQSEG, 3'd0,
								(fix_q == 7'd0) ? ftimer_q : TM_NONE, ERR_OK, inv_q, 1'b0);
							o_n.segment_index = done_q + 8'(fix_q);
							o_n.last = !(({1'b0, fix_q} + 8'd1 < {1'b0, win_q}) &&
								({1'b0, done_q} + {2'b0, fix_q} + 9'd1 < {1'b0, tot_q}));
							ovalid_n = 1'b1;
							fix_q <= fix_q + 7'd1;
						end else st_n = S_IDLE;
					end
				end
				S_EMIT2: begin
					if (out_ch.ready) begin
						o_n = mk(e2_dest_q, e2_act_q, (e2_act_q == ACT_ABORT) ? e2_kind_q : 3'd0,
							TM_NONE, ERR_OK, inv_q, 1'b1);
						ovalid_n = 1'b1; st_n = S_IDLE;
					end
				end
				default: st_n = S_IDLE;
			endcase
			st_q <= st_n;
			ovalid_q <= ovalid_n;
			o_q <= o_n;
		end
	end
endmodule

### hdl/segmented_request_client_fsm_core.sv
// segmented request client transaction controller
// channels: in_ch carries one event word (client request, network pdu or
// timer expiry); out_ch carries result words, the final word of an event has
// last set. cfg_we/cfg_index/cfg_data write retry_limit, proposed_window,
// segmentation_mode and local_max_apdu; write only while idle.
// sequence: accepting an event latches it and starts the segment count
// divider, which yields one quotient bit per cycle; the decide state then
// produces the first result word.
// flow: one event at a time; window fill emits one segment word per cycle
// while the output is not held.
// reset: arst_n clears phase to idle, all counters to zero, window to one and
// loads the register defaults (3, 1, 3, 1476).
// stall: a held output word stalls the fill sequence and the second word of
// a two-word result; no input is taken until all words of an event are gone.
module segmented_request_client_fsm_core
	import srcf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	srcf_in_if.sink in_ch,
	srcf_out_if.source out_ch,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [10:0] cfg_data
);
	dp_cmd_t cmd;
	in_word_t w_q;
	logic div_busy;
	logic [8:0] count;
	logic [3:0] retry_limit;
	logic [6:0] proposed_window;
	logic [1:0] segmentation_mode;
	logic [10:0] local_max_apdu;

	// datapath: registers, latched word, segment count divider
	srcf_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_word(in_ch.data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.w_q(w_q), .div_busy(div_busy), .count(count),
		.retry_limit(retry_limit), .proposed_window(proposed_window),
		.segmentation_mode(segmentation_mode), .local_max_apdu(local_max_apdu)
	);

	// controller: transaction state and result sequencing
	srcf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.w_q(w_q), .div_busy(div_busy), .count(count),
		.retry_limit(retry_limit), .proposed_window(proposed_window),
		.segmentation_mode(segmentation_mode), .local_max_apdu(local_max_apdu),
		.cmd(cmd)
	);

	// no new word while results are pending
	a_no_accept_when_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("input taken while output pending");
	// divider starts only on accept
	a_div_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> cmd.load) else $error("divider started without accept");
	// after accept a result cannot appear in the next cycle
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !out_ch.valid) else $error("early result");
endmodule
